// ----- hw/rtl/bpds_pkg.sv -----
// ----------------------------------------------------------------------------
// bpds_pkg
// Shared types and constants of the button press duration statistics block.
// ----------------------------------------------------------------------------
package bpds_pkg;

	localparam int NUM_TASKS = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W = 32;
	localparam int CNT_W = 16;
	localparam int TOG_W = 5;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Task slots in the countdown arrays.
	localparam int TASK_BUTTON = 0;
	localparam int TASK_STATS = 1;
	localparam int TASK_REPORT = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATS_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STATS_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_OFFSET = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_THRESHOLD = 3'd6;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] RST_BUTTON_PERIOD = 16'd20;
	localparam logic [CFG_DATA_W-1:0] RST_BUTTON_OFFSET = 16'd0;
	localparam logic [CFG_DATA_W-1:0] RST_STATS_PERIOD = 16'd50;
	localparam logic [CFG_DATA_W-1:0] RST_STATS_OFFSET = 16'd10;
	localparam logic [CFG_DATA_W-1:0] RST_REPORT_PERIOD = 16'd10000;
	localparam logic [CFG_DATA_W-1:0] RST_REPORT_OFFSET = 16'd20;
	localparam logic [CFG_DATA_W-1:0] RST_LONG_THRESHOLD = 16'd500;

	localparam logic [TOG_W-1:0] LONG_TOGGLES = 5'd20;
	localparam logic [TOG_W-1:0] SHORT_TOGGLES = 5'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic step_btn;
		logic step_stats;
		logic step_report;
		logic div_step;
		logic out_load;
	} bpds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_last;
	} bpds_status_t;

endpackage

// ----- hw/rtl/button_press_duration_stats.sv -----
// ----------------------------------------------------------------------------
// button_press_duration_stats
// Millisecond tick scheduler that times button presses, keeps press
// statistics, blinks a lamp and reports counts with an average duration.
//
// Channel   Direction  Handshake             Beat contents
// in        in         in_valid / in_ready   button_level
// out       out        out_valid / out_ready lamps, press and report fields
// cfg       in         cfg_we                cfg_index, cfg_data
//
// A tick's result passes through the button, stats and report steps, and on a
// report tick with at least one counted press through the 32-step serial
// divider, before it enters the output register; the next tick can be
// accepted once that result has been loaded.
// A result waits in the output register while the next tick is accepted and
// worked on; a tick only stalls once its result is ready and the register
// is still full.
// Reset is asynchronous; no clearing pass, the block takes ticks right after.
// ----------------------------------------------------------------------------
module button_press_duration_stats import bpds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  button_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  green_lamp,
	output logic                  red_lamp,
	output logic                  yellow_lamp,
	output logic                  press_done,
	output logic [TIME_W-1:0]     press_length,
	output logic                  press_long,
	output logic                  report_valid,
	output logic [CNT_W-1:0]      report_total,
	output logic [CNT_W-1:0]      report_short,
	output logic [CNT_W-1:0]      report_long,
	output logic [TIME_W-1:0]     report_average,
	output logic                  average_valid,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	bpds_cmd_t    cmd;
	bpds_status_t status;

	bpds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bpds_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.button_level   (button_level),
		.green_lamp     (green_lamp),
		.red_lamp       (red_lamp),
		.yellow_lamp    (yellow_lamp),
		.press_done     (press_done),
		.press_length   (press_length),
		.press_long     (press_long),
		.report_valid   (report_valid),
		.report_total   (report_total),
		.report_short   (report_short),
		.report_long    (report_long),
		.report_average (report_average),
		.average_valid  (average_valid)
	);

endmodule

// ----- hw/rtl/bpds_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpds_ctrl
// Sequencer: steps one tick through the button, stats and report tasks, runs
// the serial divider when a report needs an average, and hands results to
// the output register.
// ----------------------------------------------------------------------------
module bpds_ctrl import bpds_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  bpds_status_t status,
	output bpds_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_BTN    = 6'b000010,
		S_STATS  = 6'b000100,
		S_REPORT = 6'b001000,
		S_DIV    = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n = S_BTN;
				end
			end
			S_BTN: begin
				cmd.step_btn = 1'b1;
				state_n = S_STATS;
			end
			S_STATS: begin
				cmd.step_stats = 1'b1;
				state_n = S_REPORT;
			end
			S_REPORT: begin
				cmd.step_report = 1'b1;
				state_n = status.need_div ? S_DIV : S_FINISH;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = S_FINISH;
				end
			end
			S_FINISH: begin
				// The output register may still hold the previous beat.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_BTN)
		else $error("accepted tick did not start the button step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before it was taken");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && status.div_last |=> state_q == S_FINISH)
		else $error("divider did not end after its last step");
`endif

endmodule

// ----- hw/rtl/bpds_dp.sv -----
// ----------------------------------------------------------------------------
// bpds_dp
// Datapath: tick counter, task countdowns, press timing, statistics counters,
// a restoring serial divider for the average, and the output register.
// ----------------------------------------------------------------------------
module bpds_dp import bpds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpds_cmd_t             cmd,
	output bpds_status_t          status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  button_level,
	output logic                  green_lamp,
	output logic                  red_lamp,
	output logic                  yellow_lamp,
	output logic                  press_done,
	output logic [TIME_W-1:0]     press_length,
	output logic                  press_long,
	output logic                  report_valid,
	output logic [CNT_W-1:0]      report_total,
	output logic [CNT_W-1:0]      report_short,
	output logic [CNT_W-1:0]      report_long,
	output logic [TIME_W-1:0]     report_average,
	output logic                  average_valid
);

	// Architectural state.
	logic [CFG_DATA_W-1:0] period_q [NUM_TASKS];
	logic [CFG_DATA_W-1:0] cd_q [NUM_TASKS];
	logic [CFG_DATA_W-1:0] thresh_q;
	logic [TIME_W-1:0]     now_q;
	logic                  was_pressed_q;
	logic [TIME_W-1:0]     start_q;
	logic                  ev_pend_q;
	logic [TIME_W-1:0]     ev_dur_q;
	logic                  ev_long_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      short_q;
	logic [CNT_W-1:0]      long_q;
	logic [TIME_W-1:0]     ssum_q;
	logic [TIME_W-1:0]     lsum_q;
	logic [TOG_W-1:0]      toggles_q;
	logic                  green_q;
	logic                  red_q;
	logic                  yellow_q;

	// Per-tick working registers.
	logic                  level_q;
	logic [NUM_TASKS-1:0]  fire_q;
	logic                  done_q;
	logic [TIME_W-1:0]     dlen_q;
	logic                  dlong_q;
	logic                  rep_q;
	logic [CNT_W-1:0]      rtot_q;
	logic [CNT_W-1:0]      rshort_q;
	logic [CNT_W-1:0]      rlong_q;
	logic                  avg_ok_q;
	logic [CNT_W-1:0]      div_q;
	logic [CNT_W-1:0]      rem_q;
	logic [TIME_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;

	// Output register.
	logic                  green_out_q;
	logic                  red_out_q;
	logic                  yellow_out_q;
	logic                  done_out_q;
	logic [TIME_W-1:0]     dlen_out_q;
	logic                  dlong_out_q;
	logic                  rep_out_q;
	logic [CNT_W-1:0]      rtot_out_q;
	logic [CNT_W-1:0]      rshort_out_q;
	logic [CNT_W-1:0]      rlong_out_q;
	logic [TIME_W-1:0]     avg_out_q;
	logic                  avg_ok_out_q;

	logic [NUM_TASKS-1:0]  fire_c;
	logic [TIME_W-1:0]     dlen_c;
	logic                  dlong_c;
	logic [TOG_W-1:0]      tog_src_c;
	logic [CNT_W:0]        rem_sh_c;
	logic [CNT_W:0]        rem_sub_c;
	logic                  rem_ge_c;

	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			fire_c[i] = (cd_q[i] <= CFG_DATA_W'(1));
		end
	end

	// now_q already holds the tick count after this tick's increment.
	assign dlen_c = now_q - start_q;
	assign dlong_c = (dlen_c >= {{(TIME_W-CFG_DATA_W){1'b0}}, thresh_q});

	// A consumed event restarts the blink sequence before this run's toggle.
	assign tog_src_c = ev_pend_q ? (ev_long_q ? LONG_TOGGLES : SHORT_TOGGLES) : toggles_q;

	assign rem_sh_c = {rem_q, quo_q[TIME_W-1]};
	assign rem_sub_c = rem_sh_c - {1'b0, div_q};
	assign rem_ge_c = (rem_sh_c >= {1'b0, div_q});

	assign status.need_div = fire_q[TASK_REPORT] && (total_q != '0);
	assign status.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q[TASK_BUTTON] <= RST_BUTTON_PERIOD;
			period_q[TASK_STATS] <= RST_STATS_PERIOD;
			period_q[TASK_REPORT] <= RST_REPORT_PERIOD;
			cd_q[TASK_BUTTON] <= RST_BUTTON_OFFSET;
			cd_q[TASK_STATS] <= RST_STATS_OFFSET;
			cd_q[TASK_REPORT] <= RST_REPORT_OFFSET;
			thresh_q <= RST_LONG_THRESHOLD;
			now_q <= TIME_W'(1);
			was_pressed_q <= 1'b0;
			start_q <= '0;
			ev_pend_q <= 1'b0;
			ev_dur_q <= '0;
			ev_long_q <= 1'b0;
			total_q <= '0;
			short_q <= '0;
			long_q <= '0;
			ssum_q <= '0;
			lsum_q <= '0;
			toggles_q <= '0;
			green_q <= 1'b0;
			red_q <= 1'b0;
			yellow_q <= 1'b0;
		end else begin
			if (cmd.step_btn) begin
				now_q <= now_q + TIME_W'(1);
				for (int i = 0; i < NUM_TASKS; i++) begin
					cd_q[i] <= fire_c[i] ? period_q[i] : cd_q[i] - CFG_DATA_W'(1);
				end
				if (fire_c[TASK_BUTTON]) begin
					if (level_q && !was_pressed_q) begin
						start_q <= now_q;
						green_q <= 1'b0;
						red_q <= 1'b0;
					end else if (!level_q && was_pressed_q) begin
						green_q <= !dlong_c;
						red_q <= dlong_c;
						ev_dur_q <= dlen_c;
						ev_long_q <= dlong_c;
						ev_pend_q <= 1'b1;
					end
					was_pressed_q <= level_q;
				end
			end
			if (cmd.step_stats && fire_q[TASK_STATS]) begin
				if (ev_pend_q) begin
					ev_pend_q <= 1'b0;
					total_q <= total_q + CNT_W'(1);
					if (ev_long_q) begin
						long_q <= long_q + CNT_W'(1);
						lsum_q <= lsum_q + ev_dur_q;
					end else begin
						short_q <= short_q + CNT_W'(1);
						ssum_q <= ssum_q + ev_dur_q;
					end
				end
				if (tog_src_c != '0) begin
					yellow_q <= !yellow_q;
					toggles_q <= tog_src_c - TOG_W'(1);
				end else begin
					yellow_q <= 1'b0;
					toggles_q <= '0;
				end
			end
			if (cmd.step_report && fire_q[TASK_REPORT]) begin
				total_q <= '0;
				short_q <= '0;
				long_q <= '0;
				ssum_q <= '0;
				lsum_q <= '0;
			end
			// An offset write restarts that task's phase at once.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BUTTON_PERIOD: period_q[TASK_BUTTON] <= cfg_data;
					REG_BUTTON_OFFSET: cd_q[TASK_BUTTON] <= cfg_data;
					REG_STATS_PERIOD: period_q[TASK_STATS] <= cfg_data;
					REG_STATS_OFFSET: cd_q[TASK_STATS] <= cfg_data;
					REG_REPORT_PERIOD: period_q[TASK_REPORT] <= cfg_data;
					REG_REPORT_OFFSET: cd_q[TASK_REPORT] <= cfg_data;
					REG_LONG_THRESHOLD: thresh_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= button_level;
		end
		if (cmd.step_btn) begin
			fire_q <= fire_c;
			done_q <= fire_c[TASK_BUTTON] && !level_q && was_pressed_q;
			dlen_q <= (fire_c[TASK_BUTTON] && !level_q && was_pressed_q) ? dlen_c : '0;
			dlong_q <= fire_c[TASK_BUTTON] && !level_q && was_pressed_q && dlong_c;
		end
		if (cmd.step_report) begin
			rep_q <= fire_q[TASK_REPORT];
			rtot_q <= fire_q[TASK_REPORT] ? total_q : '0;
			rshort_q <= fire_q[TASK_REPORT] ? short_q : '0;
			rlong_q <= fire_q[TASK_REPORT] ? long_q : '0;
			avg_ok_q <= status.need_div;
			div_q <= total_q;
			rem_q <= '0;
			div_cnt_q <= '0;
			quo_q <= status.need_div ? ssum_q + lsum_q : '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge_c ? rem_sub_c[CNT_W-1:0] : rem_sh_c[CNT_W-1:0];
			quo_q <= {quo_q[TIME_W-2:0], rem_ge_c};
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.out_load) begin
			green_out_q <= green_q;
			red_out_q <= red_q;
			yellow_out_q <= yellow_q;
			done_out_q <= done_q;
			dlen_out_q <= dlen_q;
			dlong_out_q <= dlong_q;
			rep_out_q <= rep_q;
			rtot_out_q <= rtot_q;
			rshort_out_q <= rshort_q;
			rlong_out_q <= rlong_q;
			avg_out_q <= quo_q;
			avg_ok_out_q <= avg_ok_q;
		end
	end

	assign green_lamp = green_out_q;
	assign red_lamp = red_out_q;
	assign yellow_lamp = yellow_out_q;
	assign press_done = done_out_q;
	assign press_length = dlen_out_q;
	assign press_long = dlong_out_q;
	assign report_valid = rep_out_q;
	assign report_total = rtot_out_q;
	assign report_short = rshort_out_q;
	assign report_long = rlong_out_q;
	assign report_average = avg_out_q;
	assign average_valid = avg_ok_out_q;

`ifndef SYNTHESIS
	a_toggles_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		toggles_q <= LONG_TOGGLES)
		else $error("blink toggle count out of range");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < div_q)
		else $error("divider remainder not below divisor");

	a_no_avg_without_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_report && !status.need_div |=> quo_q == '0 && !avg_ok_q)
		else $error("average present without a division");
`endif

endmodule

// ----- dv/button_press_duration_stats_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_duration_stats_tb
// Drives millisecond ticks with button levels into the block and checks every
// result beat against a cycle-free predictor of the scheduler, press timer,
// statistics and report tasks. A directed script comes first, then random
// press sequences under several register settings, with random idling on both
// channels and a long output hold-off.
// ----------------------------------------------------------------------------
module button_press_duration_stats_tb;
	import bpds_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_TICKS = 150;

	typedef struct packed {
		logic              green;
		logic              red;
		logic              yellow;
		logic              done;
		logic [TIME_W-1:0] length;
		logic              plong;
		logic              rep;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  n_short;
		logic [CNT_W-1:0]  n_long;
		logic [TIME_W-1:0] avg;
		logic              avg_ok;
	} tick_result_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		logic                  level;
		logic                  typed;
		tick_result_t          want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  button_level = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  green_lamp;
	logic                  red_lamp;
	logic                  yellow_lamp;
	logic                  press_done;
	logic [TIME_W-1:0]     press_length;
	logic                  press_long;
	logic                  report_valid;
	logic [CNT_W-1:0]      report_total;
	logic [CNT_W-1:0]      report_short;
	logic [CNT_W-1:0]      report_long;
	logic [TIME_W-1:0]     report_average;
	logic                  average_valid;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	button_press_duration_stats uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.button_level  (button_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.green_lamp    (green_lamp),
		.red_lamp      (red_lamp),
		.yellow_lamp   (yellow_lamp),
		.press_done    (press_done),
		.press_length  (press_length),
		.press_long    (press_long),
		.report_valid  (report_valid),
		.report_total  (report_total),
		.report_short  (report_short),
		.report_long   (report_long),
		.report_average(report_average),
		.average_valid (average_valid),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Predictor state: a private copy of the block's registers and task state.
	logic [CFG_DATA_W-1:0] task_period [NUM_TASKS];
	logic [CFG_DATA_W-1:0] countdown [NUM_TASKS];
	logic [CFG_DATA_W-1:0] press_threshold;
	logic [TIME_W-1:0]     now_ms;
	logic                  was_down;
	logic [TIME_W-1:0]     down_since;
	logic                  evt_pending;
	logic [TIME_W-1:0]     evt_len;
	logic                  evt_long;
	logic [CNT_W-1:0]      n_presses;
	logic [CNT_W-1:0]      n_short_presses;
	logic [CNT_W-1:0]      n_long_presses;
	logic [TIME_W-1:0]     short_sum;
	logic [TIME_W-1:0]     long_sum;
	logic [TOG_W-1:0]      blinks_left;
	logic                  lamp_g;
	logic                  lamp_r;
	logic                  lamp_y;

	tick_result_t tick_results_due[$];
	script_row_t  script[$];

	int  fail_count = 0;
	int  ticks_sent = 0;
	int  settings_used = 0;
	int  releases_seen = 0;
	int  long_seen = 0;
	int  reports_seen = 0;
	int  averages_seen = 0;
	bit  send_gaps = 1'b0;
	bit  recv_stalls = 1'b0;
	bit  hold_off_req = 1'b0;

	function automatic void predictor_reset();
		task_period[TASK_BUTTON] = RST_BUTTON_PERIOD;
		task_period[TASK_STATS] = RST_STATS_PERIOD;
		task_period[TASK_REPORT] = RST_REPORT_PERIOD;
		countdown[TASK_BUTTON] = RST_BUTTON_OFFSET;
		countdown[TASK_STATS] = RST_STATS_OFFSET;
		countdown[TASK_REPORT] = RST_REPORT_OFFSET;
		press_threshold = RST_LONG_THRESHOLD;
		now_ms = '0;
		was_down = 1'b0;
		down_since = '0;
		evt_pending = 1'b0;
		evt_len = '0;
		evt_long = 1'b0;
		n_presses = '0;
		n_short_presses = '0;
		n_long_presses = '0;
		short_sum = '0;
		long_sum = '0;
		blinks_left = '0;
		lamp_g = 1'b0;
		lamp_r = 1'b0;
		lamp_y = 1'b0;
	endfunction

	// An offset write restarts that task's phase at once; a period waits for a reload.
	function automatic void set_register(logic [CFG_IDX_W-1:0] idx,
	                                     logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_BUTTON_PERIOD: task_period[TASK_BUTTON] = value;
			REG_BUTTON_OFFSET: countdown[TASK_BUTTON] = value;
			REG_STATS_PERIOD: task_period[TASK_STATS] = value;
			REG_STATS_OFFSET: countdown[TASK_STATS] = value;
			REG_REPORT_PERIOD: task_period[TASK_REPORT] = value;
			REG_REPORT_OFFSET: countdown[TASK_REPORT] = value;
			REG_LONG_THRESHOLD: press_threshold = value;
			default: ;
		endcase
	endfunction

	function automatic bit slot_fires(int slot);
		if (countdown[slot] <= 1) begin
			countdown[slot] = task_period[slot];
			return 1'b1;
		end
		countdown[slot] = countdown[slot] - 1'b1;
		return 1'b0;
	endfunction

	function automatic tick_result_t predict_tick(logic level);
		tick_result_t r;
		logic [TIME_W-1:0] held;
		logic [TIME_W-1:0] sum;
		r = '0;
		now_ms = now_ms + 1;
		if (slot_fires(TASK_BUTTON)) begin
			if (level && !was_down) begin
				down_since = now_ms;
				lamp_g = 1'b0;
				lamp_r = 1'b0;
			end else if (!level && was_down) begin
				held = now_ms - down_since;
				r.done = 1'b1;
				r.length = held;
				r.plong = held >= {16'd0, press_threshold};
				lamp_r = r.plong;
				lamp_g = !r.plong;
				// A release not yet counted by the stats task is simply replaced.
				evt_len = held;
				evt_long = r.plong;
				evt_pending = 1'b1;
			end
			was_down = level;
		end
		if (slot_fires(TASK_STATS)) begin
			if (evt_pending) begin
				evt_pending = 1'b0;
				n_presses = n_presses + 1'b1;
				if (evt_long) begin
					n_long_presses = n_long_presses + 1'b1;
					long_sum = long_sum + evt_len;
					blinks_left = LONG_TOGGLES;
				end else begin
					n_short_presses = n_short_presses + 1'b1;
					short_sum = short_sum + evt_len;
					blinks_left = SHORT_TOGGLES;
				end
			end
			if (blinks_left != 0) begin
				lamp_y = !lamp_y;
				blinks_left = blinks_left - 1'b1;
			end else begin
				lamp_y = 1'b0;
			end
		end
		if (slot_fires(TASK_REPORT)) begin
			r.rep = 1'b1;
			r.total = n_presses;
			r.n_short = n_short_presses;
			r.n_long = n_long_presses;
			if (n_presses != 0) begin
				sum = short_sum + long_sum;
				r.avg_ok = 1'b1;
				r.avg = sum / {16'd0, n_presses};
			end
			n_presses = '0;
			n_short_presses = '0;
			n_long_presses = '0;
			short_sum = '0;
			long_sum = '0;
		end
		r.green = lamp_g;
		r.red = lamp_r;
		r.yellow = lamp_y;
		return r;
	endfunction

	function automatic tick_result_t quiet(logic g, logic r, logic y);
		tick_result_t res;
		res = '0;
		res.green = g;
		res.red = r;
		res.yellow = y;
		return res;
	endfunction

	function automatic tick_result_t released(logic [TIME_W-1:0] len, logic is_long);
		tick_result_t res;
		res = quiet(!is_long, is_long, 1'b0);
		res.done = 1'b1;
		res.length = len;
		res.plong = is_long;
		return res;
	endfunction

	function automatic script_row_t tick_row(logic level);
		script_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.level = level;
		return row;
	endfunction

	function automatic script_row_t typed_row(logic level, tick_result_t want);
		script_row_t row;
		row = tick_row(level);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic script_row_t write_row(logic [CFG_IDX_W-1:0] idx,
	                                          logic [CFG_DATA_W-1:0] value);
		script_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_index = idx;
		row.reg_value = value;
		return row;
	endfunction

	// Mostly short idles, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(12, 45);
	endfunction

	task automatic send_tick(logic level, logic typed, tick_result_t want);
		int gap;
		tick_result_t predicted;
		gap = (send_gaps && $urandom_range(0, 9) < 4) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_level <= level;
		do @(posedge clk); while (!in_ready);
		predicted = predict_tick(level);
		tick_results_due.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	// Waits until every tick in flight has produced its result.
	task automatic settle();
		while (tick_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		set_register(idx, value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic configure(int bp, int bo, int sp, int so, int rp, int ro, int thr);
		in_valid <= 1'b0;
		settle();
		write_reg(REG_BUTTON_PERIOD, bp[15:0]);
		write_reg(REG_BUTTON_OFFSET, bo[15:0]);
		write_reg(REG_STATS_PERIOD, sp[15:0]);
		write_reg(REG_STATS_OFFSET, so[15:0]);
		write_reg(REG_REPORT_PERIOD, rp[15:0]);
		write_reg(REG_REPORT_OFFSET, ro[15:0]);
		write_reg(REG_LONG_THRESHOLD, thr[15:0]);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Press/release runs sized around the threshold and the button period, so
	// both short and long presses get sampled; the rest is level noise.
	task automatic run_presses(int n_items, int bp, int thr);
		int sent;
		int run;
		int k;
		int cap;
		int bpl;
		sent = 0;
		cap = (thr > 80) ? 80 : thr;
		bpl = (bp > 10) ? 10 : bp;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				run = $urandom_range(1, cap + 3 * bpl + 2);
				for (k = 0; k < run && sent < n_items; k++) begin
					send_tick(1'b1, 1'b0, '0);
					sent++;
				end
				run = $urandom_range(1, 2 * bpl + 4);
				for (k = 0; k < run && sent < n_items; k++) begin
					send_tick(1'b0, 1'b0, '0);
					sent++;
				end
			end else begin
				run = $urandom_range(1, 6);
				for (k = 0; k < run && sent < n_items; k++) begin
					send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tick_result_t got;
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {green_lamp, red_lamp, yellow_lamp, press_done, press_length, press_long,
			       report_valid, report_total, report_short, report_long, report_average,
			       average_valid};
			if (tick_results_due.size() == 0) begin
				$error("result beat arrived with no tick waiting for it");
				fail_count++;
			end else begin
				want = tick_results_due.pop_front();
				check_field("green_lamp", 32'(want.green), 32'(got.green));
				check_field("red_lamp", 32'(want.red), 32'(got.red));
				check_field("yellow_lamp", 32'(want.yellow), 32'(got.yellow));
				check_field("press_done", 32'(want.done), 32'(got.done));
				check_field("press_length", want.length, got.length);
				check_field("press_long", 32'(want.plong), 32'(got.plong));
				check_field("report_valid", 32'(want.rep), 32'(got.rep));
				check_field("report_total", 32'(want.total), 32'(got.total));
				check_field("report_short", 32'(want.n_short), 32'(got.n_short));
				check_field("report_long", 32'(want.n_long), 32'(got.n_long));
				check_field("report_average", want.avg, got.avg);
				check_field("average_valid", 32'(want.avg_ok), 32'(got.avg_ok));
				releases_seen += int'(want.done);
				long_seen += int'(want.plong);
				reports_seen += int'(want.rep);
				averages_seen += int'(want.avg_ok);
			end
		end
	end

	// Output side: random stalls, plus a long hold-off on request so the block
	// fills up and pushes back on the tick channel.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (recv_stalls && $urandom_range(0, 9) < 3) begin
				out_ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("button_press_duration_stats verification failed");
		$finish;
	end

	initial begin : stimulus
		tick_result_t rpt;
		script_row_t row;
		bit writing;
		int ph;
		int bp;
		int sp;
		int rp;

		predictor_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script. The first tick after reset is quiet; then the button
		// task runs every tick with the other tasks parked far away, to time
		// presses at, below and above the threshold.
		script.push_back(typed_row(1'b0, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(write_row(REG_BUTTON_PERIOD, 16'd1));
		script.push_back(write_row(REG_BUTTON_OFFSET, 16'd0));
		script.push_back(write_row(REG_STATS_PERIOD, 16'hFFFF));
		script.push_back(write_row(REG_STATS_OFFSET, 16'hFFFF));
		script.push_back(write_row(REG_REPORT_PERIOD, 16'hFFFF));
		script.push_back(write_row(REG_REPORT_OFFSET, 16'hFFFF));
		script.push_back(write_row(REG_LONG_THRESHOLD, 16'd3));
		script.push_back(typed_row(1'b1, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(typed_row(1'b1, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(typed_row(1'b1, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(typed_row(1'b0, released(3, 1'b1)));
		script.push_back(typed_row(1'b1, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(typed_row(1'b0, released(1, 1'b0)));
		script.push_back(typed_row(1'b0, quiet(1'b1, 1'b0, 1'b0)));
		script.push_back(write_row(REG_LONG_THRESHOLD, 16'd0));
		script.push_back(typed_row(1'b1, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(typed_row(1'b0, released(1, 1'b1)));
		script.push_back(write_row(REG_LONG_THRESHOLD, 16'hFFFF));
		script.push_back(typed_row(1'b1, quiet(1'b0, 1'b0, 1'b0)));
		script.push_back(typed_row(1'b0, released(1, 1'b0)));
		// The stats task wakes up and counts only the latest release; the report
		// runs in the same tick.
		script.push_back(write_row(REG_STATS_PERIOD, 16'd1));
		script.push_back(write_row(REG_STATS_OFFSET, 16'd0));
		script.push_back(write_row(REG_REPORT_OFFSET, 16'd1));
		rpt = quiet(1'b1, 1'b0, 1'b1);
		rpt.rep = 1'b1;
		rpt.total = 16'd1;
		rpt.n_short = 16'd1;
		rpt.avg = 32'd1;
		rpt.avg_ok = 1'b1;
		script.push_back(typed_row(1'b0, rpt));
		script.push_back(tick_row(1'b1));
		script.push_back(tick_row(1'b1));
		script.push_back(tick_row(1'b0));
		// Zero periods: button and report tasks run on every tick.
		script.push_back(write_row(REG_REPORT_PERIOD, 16'd0));
		script.push_back(write_row(REG_REPORT_OFFSET, 16'd0));
		script.push_back(write_row(REG_BUTTON_PERIOD, 16'd0));
		script.push_back(write_row(REG_LONG_THRESHOLD, 16'd2));
		script.push_back(tick_row(1'b0));
		script.push_back(tick_row(1'b0));
		script.push_back(tick_row(1'b1));
		script.push_back(tick_row(1'b1));
		script.push_back(tick_row(1'b1));
		script.push_back(tick_row(1'b0));
		script.push_back(tick_row(1'b0));
		script.push_back(tick_row(1'b1));
		script.push_back(tick_row(1'b0));

		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		writing = 1'b0;
		settings_used = 1;
		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing) begin
					in_valid <= 1'b0;
					settle();
					writing = 1'b1;
					settings_used++;
				end
				write_reg(row.reg_index, row.reg_value);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				send_tick(row.level, row.typed, row.want);
			end
		end

		// Extreme settings: nothing ever due, then everything due every tick.
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		configure(65535, 65535, 65535, 65535, 65535, 65535, 65535);
		run_presses(40, 65535, 65535);
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		configure(1, 0, 1, 0, 1, 0, 0);
		run_presses(60, 1, 0);
		configure(0, 0, 0, 0, 0, 1, 65535);
		run_presses(60, 0, 65535);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			bp = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
			sp = $urandom_range(1, 25);
			rp = $urandom_range(15, 250);
			configure(bp, $urandom_range(0, bp), sp, $urandom_range(0, sp),
			          rp, $urandom_range(0, rp), $urandom_range(0, 60));
			send_gaps = (ph % 3) != 0;
			recv_stalls = (ph % 4) != 0;
			if (ph == 1 || ph == 5) begin
				// Keep offering ticks back to back while the output is held off.
				send_gaps = 1'b0;
				hold_off_req = 1'b1;
			end
			run_presses(PHASE_TICKS, bp, 60);
		end

		in_valid <= 1'b0;
		settle();
		$display("Sent %0d ticks under %0d register settings.", ticks_sent, settings_used);
		$display("Saw %0d releases (%0d long) and %0d reports, %0d with an average.",
		         releases_seen, long_seen, reports_seen, averages_seen);
		if (fail_count == 0)
			$display("button_press_duration_stats verification clean");
		else
			$display("button_press_duration_stats verification failed");
		$finish;
	end

endmodule
